// File: hw/rtl/mkdh_pkg.sv
// Shared types, constants and helpers for the multi-key debouncer.
package mkdh_pkg;

  localparam int NUM_KEYS   = 6;
  localparam int CODE_REGS  = 6;
  localparam int KEY_W      = 3;
  localparam int CODE_W     = 10;
  localparam int DELAY_W    = 8;
  localparam int HOLD_W     = 16;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam int KEY_IDX_W  = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  localparam int RUNQ_DEPTH = 4;
  localparam int RUNQ_AW    = $clog2(RUNQ_DEPTH);
  localparam int RUNQ_CW    = $clog2(RUNQ_DEPTH + 1);

  localparam int REG_DELAY   = 0;
  localparam int REG_HOLDOFF = 1;
  localparam int REG_CODE0   = 2;

  localparam logic [DELAY_W-1:0] DELAY_RESET   = DELAY_W'(5);
  localparam logic [HOLD_W-1:0]  HOLDOFF_RESET = HOLD_W'(60);
  localparam logic [HOLD_W-1:0]  SINCE_MAX     = '1;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_EDGE = 1'b1
  } op_t;

  typedef logic [NUM_KEYS-1:0] key_mask_t;

  typedef struct packed {
    op_t              operation;
    logic [KEY_W-1:0] key_index;
  } in_item_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key_number;
    logic [CODE_W-1:0] event_code;
    logic              last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [DELAY_W-1:0]                delay_ticks;
    logic [HOLD_W-1:0]                 holdoff_ticks;
    logic [NUM_KEYS-1:0][CODE_W-1:0]   codes;
  } cfg_t;

  // one tick's set of accepted presses, pushed into the run queue
  typedef struct packed {
    logic      push;
    key_mask_t mask;
  } run_push_t;

  function automatic logic [CODE_W-1:0] code_reset(input int k);
    logic [CODE_W-1:0] c;
    unique case (k)
      0:       c = CODE_W'(103);
      1:       c = CODE_W'(108);
      2:       c = CODE_W'(105);
      3:       c = CODE_W'(106);
      4:       c = CODE_W'(28);
      5:       c = CODE_W'(1);
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

// File: hw/rtl/multi_key_debounce_holdoff.sv
// Top level of the six-key debouncer with per-key repeat hold-off.
//
//  port group   direction  flow control     content
//  in_*         input      valid / stall    tick or falling edge on one key
//  out_*        output     valid / stall    one accepted press, lowest key first
//  cfg_*        input      write enable     delay, hold-off, key codes
//
// One request is accepted per cycle while in_stall is low; per-key state updates from the
// input register. A tick's presses drain from a 4-entry run queue, one result per cycle
// while out_stall allows. Results pass from the run queue into the out_* register.
// in_stall rises only while the run queue is full, which out_stall back-pressure causes.
// rst_n is synchronous: all per-key state clears, config takes its reset values.
module multi_key_debounce_holdoff import mkdh_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t      cfg;
  run_push_t run_push;
  logic      q_full;

  mkdh_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  mkdh_keys u_keys (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .run_push (run_push)
  );

  mkdh_runq u_runq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .run_push  (run_push),
    .q_full    (q_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: hw/rtl/mkdh_cfg.sv
// Configuration register file: delay, hold-off and per-key event codes.
module mkdh_cfg import mkdh_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.delay_ticks   <= DELAY_RESET;
      cfg_r.holdoff_ticks <= HOLDOFF_RESET;
      for (int k = 0; k < NUM_KEYS; k++) begin
        cfg_r.codes[k] <= code_reset(k);
      end
    end else if (cfg_we) begin
      if (cfg_index == CFG_IDX_W'(REG_DELAY)) begin
        cfg_r.delay_ticks <= cfg_wdata[DELAY_W-1:0];
      end
      if (cfg_index == CFG_IDX_W'(REG_HOLDOFF)) begin
        cfg_r.holdoff_ticks <= cfg_wdata[HOLD_W-1:0];
      end
      for (int k = 0; k < NUM_KEYS; k++) begin
        if (k < CODE_REGS && cfg_index == CFG_IDX_W'(REG_CODE0 + k)) begin
          cfg_r.codes[k] <= cfg_wdata[CODE_W-1:0];
        end
      end
    end
  end

  assign cfg = cfg_r;

endmodule

// File: hw/rtl/mkdh_keys.sv
// Input register and per-key debounce/hold-off state, updated once per request.
module mkdh_keys import mkdh_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  input  logic      q_full,
  output run_push_t run_push
);

  logic     in_vld_r, in_vld_nxt;
  in_item_t in_r;
  logic     accept, advance;

  logic [NUM_KEYS-1:0]              pend_r, pend_nxt;
  logic [NUM_KEYS-1:0]              has_r, has_nxt;
  logic [NUM_KEYS-1:0][DELAY_W-1:0] dcnt_r, dcnt_nxt;
  logic [NUM_KEYS-1:0][HOLD_W-1:0]  since_r, since_nxt;
  key_mask_t                        fire;
  logic [DELAY_W-1:0]               arm_val;
  logic [DELAY_W-1:0]               dc1;
  logic [HOLD_W-1:0]                sr1;

  assign in_stall = in_vld_r && q_full;
  assign accept   = in_valid && !in_stall;
  assign advance  = in_vld_r && !q_full;

  always_comb begin
    if (accept) begin
      in_vld_nxt = 1'b1;
    end else if (advance) begin
      in_vld_nxt = 1'b0;
    end else begin
      in_vld_nxt = in_vld_r;
    end
  end

  assign arm_val = (cfg.delay_ticks == '0) ? DELAY_W'(1) : cfg.delay_ticks;

  always_comb begin
    pend_nxt  = pend_r;
    has_nxt   = has_r;
    dcnt_nxt  = dcnt_r;
    since_nxt = since_r;
    fire      = '0;
    dc1       = '0;
    sr1       = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      if (in_r.operation == OP_EDGE) begin
        if (int'(in_r.key_index) == k && !pend_r[k]) begin
          pend_nxt[k] = 1'b1;
          dcnt_nxt[k] = arm_val;
        end
      end else begin
        sr1 = (has_r[k] && since_r[k] != SINCE_MAX) ? since_r[k] + HOLD_W'(1) : since_r[k];
        since_nxt[k] = sr1;
        if (pend_r[k]) begin
          dc1 = (dcnt_r[k] != '0) ? dcnt_r[k] - DELAY_W'(1) : dcnt_r[k];
          dcnt_nxt[k] = dc1;
          if (dc1 == '0) begin
            pend_nxt[k] = 1'b0;
            if (!(has_r[k] && sr1 < cfg.holdoff_ticks)) begin
              since_nxt[k] = '0;
              has_nxt[k]   = 1'b1;
              fire[k]      = 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      pend_r   <= '0;
      has_r    <= '0;
      dcnt_r   <= '0;
      since_r  <= '0;
    end else begin
      in_vld_r <= in_vld_nxt;
      if (advance) begin
        pend_r  <= pend_nxt;
        has_r   <= has_nxt;
        dcnt_r  <= dcnt_nxt;
        since_r <= since_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_r <= in_data;
    end
  end

  assign run_push.push = advance && (fire != '0);
  assign run_push.mask = fire;

endmodule

// File: hw/rtl/mkdh_runq.sv
// Queue of per-tick press masks, drained one result per cycle into the output register unless out_stall holds it.
module mkdh_runq import mkdh_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  run_push_t run_push,
  output logic      q_full,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  key_mask_t            mem_r [RUNQ_DEPTH];
  logic [RUNQ_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [RUNQ_CW-1:0]   cnt_r, cnt_nxt;
  key_mask_t            taken_r, taken_nxt;
  logic                 out_vld_r, out_vld_nxt;
  out_item_t            out_r;

  key_mask_t            head, rem, bit_sel;
  logic [KEY_IDX_W-1:0] sel;
  logic                 load, pop, last;

  assign q_full = (cnt_r == RUNQ_CW'(RUNQ_DEPTH));
  assign head   = mem_r[rd_ptr_r];
  assign rem    = head & ~taken_r;

  always_comb begin
    sel     = '0;
    bit_sel = '0;
    for (int k = NUM_KEYS - 1; k >= 0; k--) begin
      if (rem[k]) begin
        sel     = KEY_IDX_W'(k);
        bit_sel = key_mask_t'(1) << k;
      end
    end
  end

  assign last = ((rem & ~bit_sel) == '0);
  assign load = (cnt_r != '0) && (!out_vld_r || !out_stall);
  assign pop  = load && last;

  always_comb begin
    cnt_nxt = cnt_r;
    if (run_push.push && !pop) begin
      cnt_nxt = cnt_r + RUNQ_CW'(1);
    end else if (!run_push.push && pop) begin
      cnt_nxt = cnt_r - RUNQ_CW'(1);
    end
    if (!load) begin
      taken_nxt = taken_r;
    end else if (last) begin
      taken_nxt = '0;
    end else begin
      taken_nxt = taken_r | bit_sel;
    end
    if (load) begin
      out_vld_nxt = 1'b1;
    end else if (out_stall) begin
      out_vld_nxt = out_vld_r;
    end else begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r  <= '0;
      rd_ptr_r  <= '0;
      cnt_r     <= '0;
      taken_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (run_push.push) begin
        wr_ptr_r <= wr_ptr_r + RUNQ_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + RUNQ_AW'(1);
      end
      cnt_r     <= cnt_nxt;
      taken_r   <= taken_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (run_push.push) begin
      mem_r[wr_ptr_r] <= run_push.mask;
    end
    if (load) begin
      out_r.key_number  <= KEY_W'(sel);
      out_r.event_code  <= cfg.codes[sel];
      out_r.last_of_run <= last;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= RUNQ_CW'(RUNQ_DEPTH))
    else $error("run queue count above depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !run_push.push)
    else $error("push into full run queue");

  a_push_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    run_push.push |-> run_push.mask != '0)
    else $error("empty press mask queued");

  a_taken_subset: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0) |-> ((taken_r & ~head) == '0) && (rem != '0))
    else $error("drain mask inconsistent with queue head");

  a_taken_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (taken_r == '0))
    else $error("partial drain with empty queue");

endmodule
